// ===== rtl/rgb2hsv_pkg.sv =====
// rgb2hsv_pkg: widths, constants and shared types of the RGB to HSV converter.
// Used by the channel interfaces and the top level; no dependencies.
`timescale 1ns / 1ps

package rgb2hsv_pkg;

	localparam int CHANNEL_BITS      = 8;
	localparam int HUE_FRACTION_BITS = 6;

	// fixed field widths of the words on the ports
	localparam int PIX_BITS = 8;
	localparam int HUE_BITS = 15;
	localparam int SAT_BITS = 8;
	localparam int BRT_BITS = 8;

	localparam int SECTOR  = 60 << HUE_FRACTION_BITS;
	localparam int CIRCLE  = 6 * SECTOR;
	localparam int HS_BITS = $clog2(CIRCLE + 1);

	// quotient widths: hue part never exceeds SECTOR, saturation never exceeds full scale
	localparam int HQ_BITS = $clog2(SECTOR + 1);
	localparam int SQ_BITS = CHANNEL_BITS;
	localparam int HN_BITS = CHANNEL_BITS + HQ_BITS;
	localparam int SN_BITS = 2 * CHANNEL_BITS;

	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = (HQ_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		chan_t   mx;
		chan_t   delta;
		chan_t   mag;
		sector_t sector;
		logic    neg;
	} cls_t;

	typedef struct packed {
		chan_t              mx;
		chan_t              delta;
		sector_t            sector;
		logic               neg;
		chan_t              hrem;
		logic [HQ_BITS-1:0] hnq;
		chan_t              srem;
		logic [SQ_BITS-1:0] snq;
	} div_st_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		logic [SAT_BITS-1:0] saturation;
		logic [BRT_BITS-1:0] brightness;
	} hsv_t;

	// one restoring division step: returns {quotient bit, new remainder}
	function automatic logic [CHANNEL_BITS:0] rem_step(input chan_t rem, input logic nbit,
			input chan_t d);
		logic [CHANNEL_BITS:0] t;
		logic [CHANNEL_BITS:0] dd;
		logic [CHANNEL_BITS:0] diff;
		t    = {rem, nbit};
		dd   = {1'b0, d};
		diff = t - dd;
		if (t >= dd) begin
			return {1'b1, diff[CHANNEL_BITS-1:0]};
		end
		return {1'b0, t[CHANNEL_BITS-1:0]};
	endfunction

endpackage

// ===== rtl/rgb2hsv_if.sv =====
// rgb2hsv_if: valid/ready channels of the converter, pixel words in, HSV words out.
// Depends on rgb2hsv_pkg.
`timescale 1ns / 1ps

interface rgb2hsv_pix_if;
	import rgb2hsv_pkg::*;

	logic                valid;
	logic                ready;
	logic [PIX_BITS-1:0] red;
	logic [PIX_BITS-1:0] green;
	logic [PIX_BITS-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgb2hsv_hsv_if;
	import rgb2hsv_pkg::*;

	logic                valid;
	logic                ready;
	logic [HUE_BITS-1:0] hue;
	logic [SAT_BITS-1:0] saturation;
	logic [BRT_BITS-1:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== rtl/rgb_to_hsv_converter.sv =====
// rgb_to_hsv_converter: pipelined RGB to HSV conversion, one pixel word per cycle unless hsv stalls.
// Depends on rgb2hsv_pkg and the channels in rgb2hsv_if.sv.
//
//   channel  dir  word
//   pix      in   red, green, blue (8b each)
//   hsv      out  hue (15b, 1/64 deg), saturation (8b), brightness (8b)
//
// Throughput one word per cycle unless hsv stalls; the stages are classify, six stages of two
// restoring division steps each for hue and saturation side by side, and compose.
// The hue divide (12 quotient bits) sets the pipeline depth.
// Reset clears the stage valid bits only.
// Each stage has its own enable, so bubbles close up under an output stall and
// pix.ready stays high while any stage is empty.
`timescale 1ns / 1ps

module rgb_to_hsv_converter (
	input  logic          clk,
	input  logic          arst_n,
	rgb2hsv_pix_if.sink   pix,
	rgb2hsv_hsv_if.source hsv
);
	import rgb2hsv_pkg::*;

	cls_t    cls_d;
	cls_t    cls_s1;
	logic    cls_v_s1;
	div_st_t div_init;
	div_st_t div_d [DIV_STAGES];
	div_st_t div_s [DIV_STAGES];
	logic    div_v_s [DIV_STAGES];
	hsv_t    hsv_d;
	hsv_t    hsv_s8;
	logic    hsv_v_s8;

	logic en_cls;
	logic en_div [DIV_STAGES];
	logic en_out;

	// stage enables, back to front
	always_comb begin
		en_out = !hsv_v_s8 || hsv.ready;
		en_div[DIV_STAGES-1] = !div_v_s[DIV_STAGES-1] || en_out;
		for (int k = DIV_STAGES - 2; k >= 0; k--) begin
			en_div[k] = !div_v_s[k] || en_div[k+1];
		end
		en_cls = !cls_v_s1 || en_div[0];
	end

	assign pix.ready = en_cls;

	// classify: max, min, sector and signed difference
	always_comb begin
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t mn;
		chan_t opa;
		chan_t opb;
		r = CHANNEL_BITS'(pix.red);
		g = CHANNEL_BITS'(pix.green);
		b = CHANNEL_BITS'(pix.blue);
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		if (r >= g && r >= b) begin
			cls_d.sector = SEC_RED;
			cls_d.mx = r;
			opa = g;
			opb = b;
		end else if (g >= b) begin
			cls_d.sector = SEC_GREEN;
			cls_d.mx = g;
			opa = b;
			opb = r;
		end else begin
			cls_d.sector = SEC_BLUE;
			cls_d.mx = b;
			opa = r;
			opb = g;
		end
		cls_d.delta = cls_d.mx - mn;
		cls_d.neg = opa < opb;
		cls_d.mag = cls_d.neg ? opb - opa : opa - opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_v_s1 <= 1'b0;
		end else if (en_cls) begin
			cls_v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_cls) begin
			cls_s1 <= cls_d;
		end
	end

	// numerators: SECTOR*mag over delta, FULL*delta over max
	always_comb begin
		logic [HN_BITS-1:0] hn;
		logic [SN_BITS-1:0] sn;
		hn = HN_BITS'(SECTOR) * HN_BITS'(cls_s1.mag);
		sn = (SN_BITS'(cls_s1.delta) << CHANNEL_BITS) - SN_BITS'(cls_s1.delta);
		div_init.mx     = cls_s1.mx;
		div_init.delta  = cls_s1.delta;
		div_init.sector = cls_s1.sector;
		div_init.neg    = cls_s1.neg;
		div_init.hrem   = hn[HN_BITS-1:HQ_BITS];
		div_init.hnq    = hn[HQ_BITS-1:0];
		div_init.srem   = sn[SN_BITS-1:CHANNEL_BITS];
		div_init.snq    = sn[CHANNEL_BITS-1:0];
	end

	always_comb begin
		div_st_t               st;
		logic [CHANNEL_BITS:0] hs;
		logic [CHANNEL_BITS:0] ss;
		hs = '0;
		ss = '0;
		st = div_init;
		for (int k = 0; k < DIV_STAGES; k++) begin
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				if (k * STEPS_PER_STAGE + j < HQ_BITS) begin
					hs = rem_step(st.hrem, st.hnq[HQ_BITS-1], st.delta);
					st.hrem = hs[CHANNEL_BITS-1:0];
					st.hnq = {st.hnq[HQ_BITS-2:0], hs[CHANNEL_BITS]};
				end
				if (k * STEPS_PER_STAGE + j < SQ_BITS) begin
					ss = rem_step(st.srem, st.snq[SQ_BITS-1], st.mx);
					st.srem = ss[CHANNEL_BITS-1:0];
					st.snq = {st.snq[SQ_BITS-2:0], ss[CHANNEL_BITS]};
				end
			end
			div_d[k] = st;
			if (k < DIV_STAGES - 1) st = div_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_v_s[k] <= 1'b0;
			end
		end else begin
			if (en_div[0]) div_v_s[0] <= cls_v_s1;
			for (int k = 1; k < DIV_STAGES; k++) begin
				if (en_div[k]) div_v_s[k] <= div_v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (en_div[k]) div_s[k] <= div_d[k];
		end
	end

	// compose: sector offset plus or minus the quotient, wrap negative red hues
	always_comb begin
		div_st_t            last;
		logic [HS_BITS-1:0] q;
		logic [HS_BITS-1:0] base;
		logic [HS_BITS-1:0] hsum;
		last = div_s[DIV_STAGES-1];
		q = HS_BITS'(last.hnq);
		case (last.sector)
			SEC_RED:   base = (last.neg && q != '0) ? HS_BITS'(CIRCLE) : '0;
			SEC_GREEN: base = HS_BITS'(2 * SECTOR);
			default:   base = HS_BITS'(4 * SECTOR);
		endcase
		hsum = last.neg ? base - q : base + q;
		if (last.delta == '0) hsum = '0;
		hsv_d.hue        = HUE_BITS'(hsum);
		hsv_d.saturation = (last.mx == '0) ? '0 : SAT_BITS'(last.snq);
		hsv_d.brightness = BRT_BITS'(last.mx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_v_s8 <= 1'b0;
		end else if (en_out) begin
			hsv_v_s8 <= div_v_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			hsv_s8 <= hsv_d;
		end
	end

	assign hsv.valid      = hsv_v_s8;
	assign hsv.hue        = hsv_s8.hue;
	assign hsv.saturation = hsv_s8.saturation;
	assign hsv.brightness = hsv_s8.brightness;

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> cls_v_s1)
		else $error("accepted pixel word did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cls_v_s1 && !en_cls |=> cls_v_s1 && $stable(cls_s1))
		else $error("stage 1 word changed while stalled");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.brightness == '0 |-> hsv.saturation == '0 && hsv.hue == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> HS_BITS'(hsv.hue) < HS_BITS'(CIRCLE))
		else $error("hue out of range");

endmodule
